[rtl/iefd_pkg.sv]
// Shared types and constants for the inverse-error weighted depth fusion block.
`timescale 1ns / 1ps

package iefd_pkg;

    localparam int QW = 24;                          // quotient bits of the divider
    localparam logic [23:0] WEIGHT_MAX = 24'hFFFFFF; // saturated weight for error 0
    localparam logic [15:0] ERR_RESET  = 16'hFFFF;

    localparam logic [1:0] DIV_WEIGHT = 2'd0;
    localparam logic [1:0] DIV_FUSE   = 2'd1;

    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  layer;
        logic [5:0]  pixel_row;
        logic [5:0]  pixel_col;
        logic [15:0] depth_value;
        logic [15:0] error_value;
    } in_t;

    typedef struct packed {
        logic [23:0] fused_depth;
        logic [15:0] mean_error;
    } out_t;

    typedef struct packed {
        logic       capture;
        logic       clr_step;
        logic       wr_store;
        logic       w_sat;
        logic       w_load;
        logic       acc_add;
        logic       next_layer;
        logic       div_start;
        logic [1:0] div_sel;
        logic       fused_load;
        logic       mean_load;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic in_query;
        logic in_store_ok;
        logic in_pix_ok;
        logic clr_last;
        logic err_zero;
        logic last_layer;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

[rtl/inverse_error_weighted_depth_fusion.sv]
// Top level of the inverse-error weighted depth fusion block.
`timescale 1ns / 1ps
//
// Usage:
//   s_ channel carries store and query requests (valid/ready). A store writes
//   depth and error for one layer/row/col and returns nothing. A query returns
//   on the m_ channel the 1/(error+1) weighted mean depth of that pixel over
//   all layers (Q16.8) and the mean of every stored error.
// Sequence:
//   store: read old error, write, back to idle.
//   query: each layer reads its entry, sets up and runs a pass of the shared
//   divider for its weight, skipping the divider when its error is 0, then
//   accumulates. Then the divider runs for the fused depth, ST_M_GO takes the
//   mean error from the running total by a reciprocal multiply and ST_OUT
//   loads the output register.
//   One request is in flight at a time; the next is taken once the result
//   sits in the output register, even while the receiver has not taken it.
// Reset:
//   after aresetn the block sweeps both stores, one entry per cycle, over all
//   LAYERS*ROWS*COLS entries (16384 at default size) with s_ready low.
// Stall:
//   a held result keeps m_valid and m_data steady; a following query waits
//   in its last state until the output register frees.

module inverse_error_weighted_depth_fusion #(
    parameter int LAYERS = 4,
    parameter int ROWS   = 64,
    parameter int COLS   = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  iefd_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output iefd_pkg::out_t m_data
);
    import iefd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    iefd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    iefd_datapath #(
        .LAYERS (LAYERS),
        .ROWS   (ROWS),
        .COLS   (COLS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[rtl/iefd_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module iefd_div #(
    parameter int N_W = 52,
    parameter int D_W = 28
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [N_W-1:0]        n,
    input  logic [D_W-1:0]        d,
    output logic                  done,
    output logic [iefd_pkg::QW-1:0] q
);
    import iefd_pkg::*;

    localparam int CW = $clog2(QW + 1);

    logic [N_W-1:0] hi;
    logic [D_W-1:0] rem_reg, rem_next;
    logic [D_W-1:0] d_reg;
    logic [QW-1:0]  low_reg;
    logic [QW-1:0]  q_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [D_W:0]   sh;
    logic           qbit;

    // quotient is known to fit QW bits, so the high part starts below d
    assign hi = n >> QW;
    assign sh = {rem_reg, low_reg[QW-1]};
    assign qbit = (sh >= {1'b0, d_reg});

    always_comb begin
        logic [D_W:0] diff;
        diff = sh - {1'b0, d_reg};
        rem_next = qbit ? diff[D_W-1:0] : sh[D_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= hi[D_W-1:0];
            low_reg <= n[QW-1:0];
            d_reg   <= d;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[QW-2:0], 1'b0};
            q_reg   <= {q_reg[QW-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

[rtl/iefd_datapath.sv]
// Sample stores, accumulators, running error total and result register.
`timescale 1ns / 1ps

module iefd_datapath #(
    parameter int LAYERS = 4,
    parameter int ROWS   = 64,
    parameter int COLS   = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  iefd_pkg::in_t   s_data,
    input  iefd_pkg::cmd_t  cmd,
    output iefd_pkg::sts_t  sts,
    output logic            m_valid,
    input  logic            m_ready,
    output iefd_pkg::out_t  m_data
);
    import iefd_pkg::*;

    localparam int PIXELS  = ROWS * COLS;
    localparam int ENTRIES = LAYERS * PIXELS;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ZW      = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int ACC_W   = 40 + $clog2(LAYERS + 1);
    localparam int DEN_W   = 24 + $clog2(LAYERS + 1);
    localparam int EW      = $clog2(ENTRIES + 1);
    localparam int TOT_W   = 16 + EW;
    localparam int N_W0    = (ACC_W + 8 > TOT_W) ? ACC_W + 8 : TOT_W;
    localparam int N_W     = (N_W0 > QW + 1) ? N_W0 : QW + 1;
    localparam int D_W     = (DEN_W > EW) ? DEN_W : EW;
    localparam logic [TOT_W-1:0] TOT_RESET = TOT_W'(64'(ERR_RESET) * 64'(ENTRIES));

    // mean error by reciprocal multiplication: the total stays below 2^NB,
    // and with RECIP = ceil(2^SH / ENTRIES) the product shifted by SH is exact
    localparam int LG = $clog2(ENTRIES);
    localparam int NB = 16 + LG;
    localparam int SH = NB + LG;
    localparam int RW = NB + 1;
    localparam logic [127:0] RECIP_WIDE = ((128'd1 << SH) + 128'(ENTRIES - 1)) / 128'(ENTRIES);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_WIDE);

    logic [15:0] dep_mem [ENTRIES];
    logic [15:0] err_mem [ENTRIES];

    in_t             req_reg;
    logic [AW-1:0]   addr_reg;
    logic [AW-1:0]   clr_cnt_reg;
    logic [ZW-1:0]   z_reg;
    logic [15:0]     rd_dep_reg;
    logic [15:0]     rd_err_reg;
    logic [23:0]     w_reg;
    logic [ACC_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [TOT_W-1:0] total_reg;
    logic [23:0]     fused_reg;
    logic [15:0]     mean_reg;
    out_t            out_reg;
    logic            out_valid_reg;

    logic [31:0]     idx_full;
    logic [1:0]      lay_sel;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [15:0]     wdep, werr;
    logic [N_W-1:0]  div_n;
    logic [D_W-1:0]  div_d;
    logic            div_done;
    logic [QW-1:0]   div_q;
    logic [39:0]     prod;
    logic [NB+RW-1:0] mean_prod;

    // a query always starts at layer 0
    assign lay_sel  = (s_data.req_type == REQ_QUERY) ? 2'd0 : s_data.layer;
    assign idx_full = 32'(lay_sel) * 32'(PIXELS) + 32'(s_data.pixel_row) * 32'(COLS)
                    + 32'(s_data.pixel_col);

    assign sts.in_query    = (s_data.req_type == REQ_QUERY);
    assign sts.in_pix_ok   = (32'(s_data.pixel_row) < 32'(ROWS)) &&
                             (32'(s_data.pixel_col) < 32'(COLS));
    assign sts.in_store_ok = sts.in_pix_ok && (32'(s_data.layer) < 32'(LAYERS));
    assign sts.clr_last    = (32'(clr_cnt_reg) == 32'(ENTRIES - 1));
    assign sts.err_zero    = (rd_err_reg == 16'd0);
    assign sts.last_layer  = (32'(z_reg) == 32'(LAYERS - 1));
    assign sts.div_done    = div_done;
    assign sts.out_free    = !out_valid_reg || m_ready;

    // store port: clearing sweep or a sample write
    assign we    = cmd.clr_step || cmd.wr_store;
    assign waddr = cmd.clr_step ? clr_cnt_reg : addr_reg;
    assign wdep  = cmd.clr_step ? 16'd0 : req_reg.depth_value;
    assign werr  = cmd.clr_step ? ERR_RESET : req_reg.error_value;

    always_ff @(posedge aclk) begin
        if (we) begin
            dep_mem[waddr] <= wdep;
            err_mem[waddr] <= werr;
        end
    end

    always_ff @(posedge aclk) begin
        rd_dep_reg <= dep_mem[addr_reg];
        rd_err_reg <= err_mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            total_reg   <= TOT_RESET;
            z_reg       <= '0;
        end else begin
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.wr_store) begin
                total_reg <= total_reg - TOT_W'(rd_err_reg) + TOT_W'(req_reg.error_value);
            end
            if (cmd.capture) begin
                z_reg <= '0;
            end else if (cmd.next_layer) begin
                z_reg <= z_reg + 1'b1;
            end
        end
    end

    assign prod      = rd_dep_reg * w_reg;
    assign mean_prod = (NB+RW)'(total_reg[NB-1:0]) * (NB+RW)'(RECIP);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg   <= s_data;
            addr_reg  <= idx_full[AW-1:0];
            num_reg   <= '0;
            den_reg   <= '0;
            fused_reg <= '0;
        end else begin
            if (cmd.next_layer) begin
                addr_reg <= addr_reg + AW'(PIXELS);
            end
            if (cmd.acc_add) begin
                num_reg <= num_reg + ACC_W'(prod);
                den_reg <= den_reg + DEN_W'(w_reg);
            end
            if (cmd.fused_load) begin
                fused_reg <= div_q[23:0];
            end
        end
        if (cmd.w_sat) begin
            w_reg <= WEIGHT_MAX;
        end else if (cmd.w_load) begin
            w_reg <= div_q[23:0];
        end
        if (cmd.mean_load) begin
            mean_reg <= mean_prod[SH +: 16];
        end
    end

    always_comb begin
        div_n = '0;
        div_d = '0;
        case (cmd.div_sel)
            DIV_WEIGHT: begin
                div_n = N_W'(1) << QW;
                div_d = D_W'(rd_err_reg) + 1'b1;
            end
            DIV_FUSE: begin
                div_n = N_W'(num_reg) << 8;
                div_d = D_W'(den_reg);
            end
            default: begin
                div_n = '0;
                div_d = '0;
            end
        endcase
    end

    iefd_div #(
        .N_W (N_W),
        .D_W (D_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .n       (div_n),
        .d       (div_d),
        .done    (div_done),
        .q       (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.fused_depth <= fused_reg;
            out_reg.mean_error  <= mean_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

[rtl/iefd_ctrl.sv]
// Request sequencer: clearing sweep, store update and per-layer query walk.
`timescale 1ns / 1ps

module iefd_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  iefd_pkg::sts_t sts,
    output iefd_pkg::cmd_t cmd
);
    import iefd_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_S_RD  = 4'd2;
    localparam logic [3:0] ST_S_WR  = 4'd3;
    localparam logic [3:0] ST_Q_RD  = 4'd4;
    localparam logic [3:0] ST_Q_W   = 4'd5;
    localparam logic [3:0] ST_Q_DIV = 4'd6;
    localparam logic [3:0] ST_Q_ACC = 4'd7;
    localparam logic [3:0] ST_F_GO  = 4'd8;
    localparam logic [3:0] ST_F_DIV = 4'd9;
    localparam logic [3:0] ST_M_GO  = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd12;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (!sts.in_query) begin
                        state_next = sts.in_store_ok ? ST_S_RD : ST_IDLE;
                    end else begin
                        state_next = sts.in_pix_ok ? ST_Q_RD : ST_M_GO;
                    end
                end
            end
            ST_S_RD: state_next = ST_S_WR;
            ST_S_WR: begin
                cmd.wr_store = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_Q_RD: state_next = ST_Q_W;
            ST_Q_W: begin
                if (sts.err_zero) begin
                    cmd.w_sat  = 1'b1;
                    state_next = ST_Q_ACC;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_WEIGHT;
                    state_next    = ST_Q_DIV;
                end
            end
            ST_Q_DIV: begin
                cmd.div_sel = DIV_WEIGHT;
                if (sts.div_done) begin
                    cmd.w_load = 1'b1;
                    state_next = ST_Q_ACC;
                end
            end
            ST_Q_ACC: begin
                cmd.acc_add = 1'b1;
                if (sts.last_layer) begin
                    state_next = ST_F_GO;
                end else begin
                    cmd.next_layer = 1'b1;
                    state_next     = ST_Q_RD;
                end
            end
            ST_F_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_FUSE;
                state_next    = ST_F_DIV;
            end
            ST_F_DIV: begin
                cmd.div_sel = DIV_FUSE;
                if (sts.div_done) begin
                    cmd.fused_load = 1'b1;
                    state_next     = ST_M_GO;
                end
            end
            ST_M_GO: begin
                cmd.mean_load = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

endmodule

[rtl/iefd_checker.sv]
// Port-level checks for the fusion block, bound to the top level.
`timescale 1ns / 1ps

module iefd_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input iefd_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input iefd_pkg::out_t m_data
);
    import iefd_pkg::*;

    // clearing sweep holds off requests right after reset
    a_clear_blocks: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("request taken during clearing sweep");

    // a held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a store never produces a result
    a_store_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.req_type == REQ_STORE) && !m_valid |=> !m_valid)
        else $error("result after a store");

    // weighted mean never exceeds the largest depth
    a_fused_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.fused_depth <= 24'hFFFF00))
        else $error("fused depth out of range");

endmodule

bind inverse_error_weighted_depth_fusion iefd_checker u_iefd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[tb/iefd_checker.sv]
// Checker for the depth fusion block: predicts query results and compares them.
`timescale 1ns / 1ps

module iefd_scoreboard (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  iefd_pkg::in_t  s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  iefd_pkg::out_t m_data,
    output int             fail_count,
    output int             pending_results,
    output int             query_count
);
    import iefd_pkg::*;

    localparam int ENTRIES = 4 * 64 * 64;

    logic [15:0]    depth_mem [ENTRIES];
    logic [15:0]    error_mem [ENTRIES];
    logic [29:0]    error_sum;
    out_t           fused_queue [$];

    function automatic logic [23:0] fuse_depth(input logic [5:0] row, input logic [5:0] col);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] w;
        int k;
        num = 0;
        den = 0;
        for (int z = 0; z < 4; z++) begin
            k = z * 4096 + row * 64 + col;
            w = (64'd1 << 24) / (64'(error_mem[k]) + 1);
            if (w > 64'(WEIGHT_MAX)) w = 64'(WEIGHT_MAX);
            num += 64'(depth_mem[k]) * w;
            den += w;
        end
        return 24'(((num << 8) / den));
    endfunction

    initial begin
        for (int k = 0; k < ENTRIES; k++) begin
            depth_mem[k] = '0;
            error_mem[k] = ERR_RESET;
        end
        error_sum = 30'(65535 * ENTRIES);
        fail_count = 0;
        query_count = 0;
        pending_results = 0;
    end

    always @(posedge aclk) begin
        int k;
        out_t want;
        if (aresetn && s_valid && s_ready) begin
            if (s_data.req_type == REQ_STORE) begin
                k = s_data.layer * 4096 + s_data.pixel_row * 64 + s_data.pixel_col;
                error_sum = error_sum - error_mem[k] + s_data.error_value;
                depth_mem[k] = s_data.depth_value;
                error_mem[k] = s_data.error_value;
            end else begin
                want.fused_depth = fuse_depth(s_data.pixel_row, s_data.pixel_col);
                want.mean_error = 16'(error_sum / ENTRIES);
                fused_queue = {fused_queue, want};
            end
        end
        if (aresetn && m_valid && m_ready) begin
            query_count++;
            if (fused_queue.size() == 0) begin
                fail_count++;
                $display("%0t: result expected none actual %h", $time, m_data);
            end else begin
                want = fused_queue.pop_front();
                if (m_data.fused_depth !== want.fused_depth) begin
                    fail_count++;
                    $display("%0t: fused_depth expected %h actual %h", $time,
                             want.fused_depth, m_data.fused_depth);
                end
                if (m_data.mean_error !== want.mean_error) begin
                    fail_count++;
                    $display("%0t: mean_error expected %h actual %h", $time,
                             want.mean_error, m_data.mean_error);
                end
            end
        end
        pending_results = fused_queue.size();
    end
endmodule

[tb/tb.sv]
// Testbench top: drives store and query requests into the depth fusion block.
`timescale 1ns / 1ps

module tb;
    import iefd_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    out_t m_data;
    int   fail_count, pending_results, query_count;
    int   send_idle = 0;   // percent of cycles the sender holds off
    int   recv_stall = 0;  // percent of cycles the receiver stalls
    int   quiet_cycles = 0;
    int   store_count = 0;

    always #4 aclk = ~aclk;

    inverse_error_weighted_depth_fusion i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    iefd_scoreboard i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_results(pending_results),
        .query_count(query_count)
    );

    // Receiver stalls at random; decided at the falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    // Watchdog: allows the post-reset sweep plus long stalled queries.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 100000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Send one request; holds valid and payload until accepted.
    // Entered and left at a falling edge; valid drops only while idling.
    task automatic send_request(input in_t req);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (req.req_type == REQ_STORE) store_count++;
        @(negedge aclk);
    endtask

    function automatic in_t make_request(input logic kind, input logic [1:0] lay,
                                         input logic [5:0] row, input logic [5:0] col,
                                         input logic [15:0] dep, input logic [15:0] err);
        in_t r;
        r.req_type = kind;
        r.layer = lay;
        r.pixel_row = row;
        r.pixel_col = col;
        r.depth_value = dep;
        r.error_value = err;
        return r;
    endfunction

    // Random request: mostly stores to a small hot region so queries see real data.
    function automatic in_t random_request();
        in_t r;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        r = raw[$bits(in_t)-1:0];
        r.req_type = ($urandom_range(99) < 40) ? REQ_QUERY : REQ_STORE;
        if ($urandom_range(99) < 80) begin
            r.pixel_row = 6'($urandom_range(3));
            r.pixel_col = 6'($urandom_range(3));
        end
        case ($urandom_range(7))
            0: r.error_value = '0;
            1: r.error_value = 16'hFFFF;
            2: r.error_value = 16'($urandom_range(15));
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1;

        // Directed: untouched pixel, field extremes, error zero saturation.
        send_request(make_request(REQ_QUERY, 2'd0, 6'd0, 6'd0, 16'd0, 16'd0));
        send_request(make_request(REQ_STORE, 2'd0, 6'd0, 6'd0, 16'hFFFF, 16'd0));
        send_request(make_request(REQ_QUERY, 2'd3, 6'd0, 6'd0, 16'hFFFF, 16'hFFFF));
        send_request(make_request(REQ_STORE, 2'd1, 6'd0, 6'd0, 16'hFFFF, 16'd0));
        send_request(make_request(REQ_STORE, 2'd2, 6'd0, 6'd0, 16'hFFFF, 16'd0));
        send_request(make_request(REQ_STORE, 2'd3, 6'd0, 6'd0, 16'hFFFF, 16'd0));
        send_request(make_request(REQ_QUERY, 2'd0, 6'd0, 6'd0, 16'd0, 16'd0));
        send_request(make_request(REQ_STORE, 2'd3, 6'd63, 6'd63, 16'h1234, 16'hFFFF));
        send_request(make_request(REQ_STORE, 2'd0, 6'd63, 6'd63, 16'd0, 16'd1));
        send_request(make_request(REQ_STORE, 2'd1, 6'd63, 6'd63, 16'h8000, 16'h00FF));
        send_request(make_request(REQ_QUERY, 2'd2, 6'd63, 6'd63, 16'hAAAA, 16'h5555));
        send_request(make_request(REQ_STORE, 2'd2, 6'd63, 6'd0, 16'h5555, 16'hAAAA));
        send_request(make_request(REQ_QUERY, 2'd1, 6'd63, 6'd0, 16'd0, 16'd0));
        send_request(make_request(REQ_QUERY, 2'd0, 6'd0, 6'd63, 16'd0, 16'd0));

        // Random phases: four idle/stall mixes.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 70; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 70; end
                default: begin send_idle = 38; recv_stall = 38; end
            endcase
            for (int n = 0; n < 500; n++) send_request(random_request());
        end
        s_valid <= 1'b0;

        while (pending_results != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Covered %0d stores and %0d query results under four idle/stall mixes.",
                 store_count, query_count);
        if (fail_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
